// ===== hw/rtl/light_pattern_sequencer_unit_assert.svh =====
// Assertion macros shared by the light pattern sequencer RTL.
// Each macro takes a label, a clock, a reset, an antecedent and a consequent.
`ifndef LIGHT_PATTERN_SEQUENCER_UNIT_ASSERT_SVH
`define LIGHT_PATTERN_SEQUENCER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define LPS_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define LPS_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`else

`define LPS_ASSERT_IMP(name, clk, rst, ante, cons)
`define LPS_ASSERT_NXT(name, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/lps_pkg.sv =====
`default_nettype none

package lps_pkg;

  // Default sizes of the style and pattern stores.
  localparam int STYLES_DEF        = 64;
  localparam int PATTERN_DEPTH_DEF = 64;

  // Field widths of the transaction channels.
  localparam int STYLE_W  = 6;
  localparam int POS_W    = 6;
  localparam int LEVEL_W  = 5;
  localparam int PLEN_W   = 7;
  localparam int OFFSET_W = 16;
  localparam int DELTA_W  = 16;
  localparam int SCALE_W  = 10;

  // Time base and frame rate.
  localparam int              TIME_W     = 32;
  localparam int              RATE_W     = 8;
  localparam logic [RATE_W-1:0] RATE_RESET = 8'd10;
  localparam int              RATE_DIV   = 1000;
  localparam int              RDIV_W     = $clog2(RATE_DIV);

  // Product of a non-negative elapsed time and the rate, and the divide unit
  // that retires DIV_BITS quotient bits per cycle.
  localparam int MUL_W     = TIME_W - 1 + RATE_W;
  localparam int DIV_BITS  = 4;
  localparam int PROD_W    = ((MUL_W + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
  localparam int DIV_STEPS = PROD_W / DIV_BITS;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  // Highest brightness level ('z').
  localparam logic [LEVEL_W-1:0] MAX_LEVEL = 5'd25;

  // Configuration port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [0:0] REG_FRAME_RATE = 1'b0;

  // Operation codes of an input transaction.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_SETUP = 2'd2
  } op_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDSTY,
    ST_MUL,
    ST_DIV,
    ST_RDPAT,
    ST_EMIT
  } state_t;

  // Brightness scale in Q2.8: floor(level * 256 / 12).
  function automatic logic [SCALE_W-1:0] level_to_scale(input logic [LEVEL_W-1:0] lvl);
    logic [SCALE_W-1:0] s;
    case (lvl)
      5'd0:    s = 10'd0;
      5'd1:    s = 10'd21;
      5'd2:    s = 10'd42;
      5'd3:    s = 10'd64;
      5'd4:    s = 10'd85;
      5'd5:    s = 10'd106;
      5'd6:    s = 10'd128;
      5'd7:    s = 10'd149;
      5'd8:    s = 10'd170;
      5'd9:    s = 10'd192;
      5'd10:   s = 10'd213;
      5'd11:   s = 10'd234;
      5'd12:   s = 10'd256;
      5'd13:   s = 10'd277;
      5'd14:   s = 10'd298;
      5'd15:   s = 10'd320;
      5'd16:   s = 10'd341;
      5'd17:   s = 10'd362;
      5'd18:   s = 10'd384;
      5'd19:   s = 10'd405;
      5'd20:   s = 10'd426;
      5'd21:   s = 10'd448;
      5'd22:   s = 10'd469;
      5'd23:   s = 10'd490;
      5'd24:   s = 10'd512;
      5'd25:   s = 10'd533;
      default: s = 10'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/light_pattern_sequencer_unit.sv =====
// Write and setup transactions return no results. A tick returns one result per
// style, and no new transaction is taken until its last result is loaded.
// Per style: style read, multiply, the 4-bit-per-cycle divide unit, pattern
// read and output load. Reset clears control, time, frame_rate (to 10) and the
// style valid bits at once; the pattern memory is not cleared.
`default_nettype none

`include "light_pattern_sequencer_unit_assert.svh"

module light_pattern_sequencer_unit #(
  parameter int STYLES        = lps_pkg::STYLES_DEF,
  parameter int PATTERN_DEPTH = lps_pkg::PATTERN_DEPTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // Input channel.
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [1:0]                            op,
  input  wire logic [lps_pkg::STYLE_W-1:0]           style,
  input  wire logic [lps_pkg::POS_W-1:0]             position,
  input  wire logic [lps_pkg::LEVEL_W-1:0]           letter_level,
  input  wire logic [lps_pkg::PLEN_W-1:0]            pattern_length,
  input  wire logic signed [lps_pkg::OFFSET_W-1:0]   start_offset,
  input  wire logic [lps_pkg::DELTA_W-1:0]           time_delta,
  // Output channel.
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [lps_pkg::STYLE_W-1:0]                style_index,
  output logic [lps_pkg::SCALE_W-1:0]                scale,
  output logic                                       last,
  // Configuration port.
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [lps_pkg::APB_ADDR_W-1:0]        paddr,
  input  wire logic [lps_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [lps_pkg::APB_DATA_W-1:0]             prdata,
  output logic                                       pready
);

  localparam int SIDX_W      = (STYLES > 1) ? $clog2(STYLES) : 1;
  localparam int LEN_W       = $clog2(PATTERN_DEPTH + 1);
  localparam int PAT_ENTRIES = STYLES * PATTERN_DEPTH;
  localparam int ADDR_W      = $clog2(PAT_ENTRIES);
  localparam int STY_W       = LEN_W + lps_pkg::TIME_W;

  lps_pkg::state_t state, state_next;

  logic [SIDX_W-1:0]              sidx;
  logic                           last_style;
  logic [lps_pkg::TIME_W-1:0]     current_time;
  logic [lps_pkg::RATE_W-1:0]     frame_rate;

  // Style store: length and start time per style, with valid bits.
  logic [STY_W-1:0]               sty_mem [STYLES];
  logic [STYLES-1:0]              sty_valid;
  logic [STY_W-1:0]               sty_rd_data;
  logic                           sty_rd_valid;

  // Pattern store: one level per style and position.
  logic [lps_pkg::LEVEL_W-1:0]    pat_mem [PAT_ENTRIES];
  logic [lps_pkg::LEVEL_W-1:0]    pat_rd_data;
  logic [ADDR_W-1:0]              pat_wr_addr;
  logic [ADDR_W-1:0]              pat_rd_addr;

  // Frame computation.
  logic [LEN_W-1:0]               cur_len;
  logic [LEN_W-1:0]               rd_len;
  logic [lps_pkg::TIME_W-1:0]     rd_start;
  logic [lps_pkg::TIME_W-1:0]     diff;
  logic [lps_pkg::MUL_W-1:0]      mul_full;
  logic [lps_pkg::PROD_W-1:0]     prod;
  logic [lps_pkg::DCNT_W-1:0]     div_cnt;
  logic [lps_pkg::RDIV_W-1:0]     div_rem;
  logic [LEN_W-1:0]               frame_rem;

  // Divide step signals.
  logic [lps_pkg::PROD_W-1:0]     step_prod;
  logic [lps_pkg::RDIV_W-1:0]     step_rem;
  logic [LEN_W-1:0]               step_frame;
  logic [lps_pkg::RDIV_W:0]       rem_wide;
  logic [LEN_W:0]                 frame_wide;
  logic                           qbit;

  // Decoded input transaction.
  logic                           in_fire;
  logic [SIDX_W-1:0]              s_clamp;
  logic [lps_pkg::LEVEL_W-1:0]    lvl_clamp;
  logic [LEN_W-1:0]               len_sat;
  logic [lps_pkg::TIME_W-1:0]     setup_start;
  logic                           pos_ok;

  logic                           emit_go;
  logic                           div_done;
  logic                           cfg_write;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == lps_pkg::REG_FRAME_RATE) ?
                     lps_pkg::APB_DATA_W'(frame_rate) : '0;

  // Input decode.
  assign in_fire     = in_valid && in_ready;
  assign s_clamp     = (32'(style) >= 32'(STYLES)) ? SIDX_W'(STYLES - 1) : SIDX_W'(style);
  assign lvl_clamp   = (letter_level > lps_pkg::MAX_LEVEL) ? lps_pkg::MAX_LEVEL : letter_level;
  assign len_sat     = (32'(pattern_length) > 32'(PATTERN_DEPTH)) ?
                       LEN_W'(PATTERN_DEPTH) : LEN_W'(pattern_length);
  assign setup_start = current_time + {{(lps_pkg::TIME_W - lps_pkg::OFFSET_W){start_offset[
                       lps_pkg::OFFSET_W-1]}}, start_offset};
  assign pos_ok      = 32'(position) < 32'(PATTERN_DEPTH);
  assign pat_wr_addr = ADDR_W'(32'(s_clamp) * 32'(PATTERN_DEPTH) + 32'(position));
  assign pat_rd_addr = ADDR_W'(32'(sidx) * 32'(PATTERN_DEPTH) + 32'(frame_rem));

  assign last_style  = (sidx == SIDX_W'(STYLES - 1));
  assign div_done    = (div_cnt == lps_pkg::DCNT_W'(lps_pkg::DIV_STEPS - 1));

  // Style read data; an entry never set up reads as length 0, start 0.
  assign rd_len   = sty_rd_valid ? sty_rd_data[STY_W-1 -: LEN_W] : '0;
  assign rd_start = sty_rd_valid ? sty_rd_data[lps_pkg::TIME_W-1:0] : '0;
  assign diff     = current_time - rd_start;
  assign mul_full = diff[lps_pkg::TIME_W-2:0] * frame_rate;

  // One divide step: DIV_BITS quotient bits of prod / 1000, each folded
  // at once into the running quotient modulo the style length.
  always_comb begin
    step_prod  = prod;
    step_rem   = div_rem;
    step_frame = frame_rem;
    rem_wide   = '0;
    frame_wide = '0;
    qbit       = 1'b0;
    for (int k = 0; k < lps_pkg::DIV_BITS; k++) begin
      rem_wide  = {step_rem, step_prod[lps_pkg::PROD_W-1]};
      step_prod = {step_prod[lps_pkg::PROD_W-2:0], 1'b0};
      qbit      = (rem_wide >= (lps_pkg::RDIV_W + 1)'(lps_pkg::RATE_DIV));
      if (qbit) begin
        rem_wide = rem_wide - (lps_pkg::RDIV_W + 1)'(lps_pkg::RATE_DIV);
      end
      step_rem   = rem_wide[lps_pkg::RDIV_W-1:0];
      frame_wide = {step_frame, qbit};
      if (frame_wide >= {1'b0, cur_len}) begin
        frame_wide = frame_wide - {1'b0, cur_len};
      end
      step_frame = frame_wide[LEN_W-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      lps_pkg::ST_IDLE: begin
        if (in_fire && (op == lps_pkg::OP_TICK)) begin
          state_next = lps_pkg::ST_RDSTY;
        end
      end
      lps_pkg::ST_RDSTY: state_next = lps_pkg::ST_MUL;
      lps_pkg::ST_MUL:   state_next = lps_pkg::ST_DIV;
      lps_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = lps_pkg::ST_RDPAT;
        end
      end
      lps_pkg::ST_RDPAT: state_next = lps_pkg::ST_EMIT;
      lps_pkg::ST_EMIT: begin
        if (emit_go) begin
          state_next = last_style ? lps_pkg::ST_IDLE : lps_pkg::ST_RDSTY;
        end
      end
      default: state_next = lps_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready = 1'b0;
    emit_go  = 1'b0;
    case (state)
      lps_pkg::ST_IDLE: in_ready = 1'b1;
      lps_pkg::ST_EMIT: emit_go  = !out_valid || out_ready;
      default: begin
        in_ready = 1'b0;
        emit_go  = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= lps_pkg::ST_IDLE;
      sidx         <= '0;
      current_time <= '0;
      frame_rate   <= lps_pkg::RATE_RESET;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write && (paddr[2] == lps_pkg::REG_FRAME_RATE)) begin
        frame_rate <= pwdata[lps_pkg::RATE_W-1:0];
      end
      if (in_fire && (op == lps_pkg::OP_TICK)) begin
        current_time <= current_time + lps_pkg::TIME_W'(time_delta);
        sidx         <= '0;
      end else if (emit_go && !last_style) begin
        sidx <= sidx + 1'b1;
      end
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Style valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      sty_valid <= '0;
    end else if (in_fire && (op == lps_pkg::OP_SETUP)) begin
      sty_valid[s_clamp] <= 1'b1;
    end
  end

  // Style memory: written by setups, read once per style of a tick.
  always_ff @(posedge clk) begin
    if (in_fire && (op == lps_pkg::OP_SETUP)) begin
      sty_mem[s_clamp] <= {len_sat, setup_start};
    end
    if (state == lps_pkg::ST_RDSTY) begin
      sty_rd_data  <= sty_mem[sidx];
      sty_rd_valid <= sty_valid[sidx];
    end
  end

  // Pattern memory: written by letter writes, read once per style of a tick.
  always_ff @(posedge clk) begin
    if (in_fire && (op == lps_pkg::OP_WRITE) && pos_ok) begin
      pat_mem[pat_wr_addr] <= lvl_clamp;
    end
    if (state == lps_pkg::ST_RDPAT) begin
      pat_rd_data <= pat_mem[pat_rd_addr];
    end
  end

  // Frame datapath: product, then the divide unit.
  always_ff @(posedge clk) begin
    if (state == lps_pkg::ST_MUL) begin
      prod      <= diff[lps_pkg::TIME_W-1] ? '0 : lps_pkg::PROD_W'(mul_full);
      cur_len   <= rd_len;
      div_cnt   <= '0;
      div_rem   <= '0;
      frame_rem <= '0;
    end else if (state == lps_pkg::ST_DIV) begin
      prod      <= step_prod;
      div_rem   <= step_rem;
      frame_rem <= step_frame;
      div_cnt   <= div_cnt + 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (emit_go) begin
      style_index <= lps_pkg::STYLE_W'(sidx);
      scale       <= (cur_len == '0) ? '0 : lps_pkg::level_to_scale(pat_rd_data);
      last        <= last_style;
    end
  end

  // Checks.
  `LPS_ASSERT_IMP(a_rem_range, clk, rst, state == lps_pkg::ST_DIV, div_rem < lps_pkg::RDIV_W'(lps_pkg::RATE_DIV))
  `LPS_ASSERT_IMP(a_frame_range, clk, rst, (state == lps_pkg::ST_RDPAT) && (cur_len != '0), frame_rem < cur_len)
  `LPS_ASSERT_NXT(a_tick_end, clk, rst, emit_go && last_style, (state == lps_pkg::ST_IDLE) && out_valid && last)
  `LPS_ASSERT_NXT(a_time_adv, clk, rst, in_fire && (op == lps_pkg::OP_TICK), current_time == ($past(current_time) + lps_pkg::TIME_W'($past(time_delta))))

endmodule

`default_nettype wire

// ===== tb/light_pattern_sequencer_unit_tb.sv =====
`timescale 1ns / 100ps

module light_pattern_sequencer_unit_tb;
  import lps_pkg::*;

  localparam int NSTYLES     = STYLES_DEF;
  localparam int NDEPTH      = PATTERN_DEPTH_DEF;
  localparam int HOLD_AFTER  = 100;
  localparam int LONG_HOLD   = 2500;
  localparam int TAIL_CYCLES = 14 * NSTYLES + 32;
  localparam int PHASE_CMDS  = 35;
  // Code 3 is not an operation; the block must drop it.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // One input transaction.
  typedef struct packed {
    logic [1:0]          op;
    logic [STYLE_W-1:0]  style;
    logic [POS_W-1:0]    position;
    logic [LEVEL_W-1:0]  level;
    logic [PLEN_W-1:0]   plen;
    logic [OFFSET_W-1:0] offset;
    logic [DELTA_W-1:0]  delta;
  } cmd_t;

  // One reported brightness.
  typedef struct packed {
    logic [STYLE_W-1:0] style_index;
    logic [SCALE_W-1:0] scale;
    logic               last;
  } scale_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic  in_valid = 1'b0;
  cmd_t  drv_cmd  = '0;
  logic  out_ready = 1'b0;
  logic  psel = 1'b0;
  logic  penable = 1'b0;
  logic  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;

  wire                 in_ready;
  wire                 out_valid;
  wire [STYLE_W-1:0]   res_style;
  wire [SCALE_W-1:0]   res_scale;
  wire                 res_last;
  wire [APB_DATA_W-1:0] prdata;
  wire                 pready;

  light_pattern_sequencer_unit dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (drv_cmd.op),
    .style          (drv_cmd.style),
    .position       (drv_cmd.position),
    .letter_level   (drv_cmd.level),
    .pattern_length (drv_cmd.plen),
    .start_offset   (drv_cmd.offset),
    .time_delta     (drv_cmd.delta),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .style_index    (res_style),
    .scale          (res_scale),
    .last           (res_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk = ~clk;

  // Commands waiting for the driver and brightness values waiting for the block.
  cmd_t       cmd_queue[$];
  scale_rec_t expected_scales[$];
  int         cmds_queued = 0;
  int         cmds_taken = 0;
  int         active_cmds = 0;
  int         results_taken = 0;
  int         errors = 0;
  bit         in_taken = 1'b0;
  bit         out_taken = 1'b0;

  // Predicted state of the sequencer.
  logic [LEVEL_W-1:0] style_pattern [NSTYLES][NDEPTH];
  bit [PLEN_W-1:0]    style_len [NSTYLES];
  bit [TIME_W-1:0]    style_start [NSTYLES];
  bit [TIME_W-1:0]    clock_ms = '0;
  bit [RATE_W-1:0]    rate_cfg = RATE_RESET;

  // Pattern entries already written, as seen when commands are generated.
  bit written_map [NSTYLES][NDEPTH];

  function automatic int idle_draw(input bit burst);
    return burst ? 0 : $urandom_range(0, 14);
  endfunction

  // Brightness of one style at the current time.
  function automatic logic [SCALE_W-1:0] style_scale_of(input int s);
    logic [TIME_W-1:0] elapsed;
    logic [63:0]       frames;
    logic [POS_W-1:0]  idx;
    if (style_len[s] == 0) return '0;
    idx = '0;
    if (style_len[s] != 1) begin
      elapsed = clock_ms - style_start[s];
      // A start still in the future shows the first entry.
      if (!elapsed[TIME_W-1]) begin
        frames = (64'(elapsed) * 64'(rate_cfg)) / 64'(RATE_DIV);
        idx = POS_W'(frames % 64'(style_len[s]));
      end
    end
    return SCALE_W'((32'(style_pattern[s][idx]) * 256) / 12);
  endfunction

  // Apply one accepted command to the predicted state.
  task automatic update_styles(input cmd_t c);
    scale_rec_t rec;
    logic [LEVEL_W-1:0] lvl;
    case (c.op)
      OP_TICK: begin
        clock_ms = clock_ms + TIME_W'(c.delta);
        for (int s = 0; s < NSTYLES; s++) begin
          rec.style_index = STYLE_W'(s);
          rec.scale = style_scale_of(s);
          rec.last = (s == NSTYLES - 1);
          expected_scales.push_back(rec);
        end
      end
      OP_WRITE: begin
        lvl = (c.level > MAX_LEVEL) ? MAX_LEVEL : c.level;
        if (c.position < NDEPTH) style_pattern[c.style][c.position] = lvl;
      end
      OP_SETUP: begin
        style_len[c.style] = (c.plen > NDEPTH) ? PLEN_W'(NDEPTH) : c.plen;
        style_start[c.style] = clock_ms + {{(TIME_W-OFFSET_W){c.offset[OFFSET_W-1]}}, c.offset};
      end
      default: ;
    endcase
  endtask

  task automatic queue_op(input logic [1:0] op, input logic [STYLE_W-1:0] s,
                          input logic [POS_W-1:0] p, input logic [LEVEL_W-1:0] lvl,
                          input logic [PLEN_W-1:0] plen, input logic [OFFSET_W-1:0] off,
                          input logic [DELTA_W-1:0] dt);
    cmd_t c;
    c.op = op;
    c.style = s;
    c.position = p;
    c.level = lvl;
    c.plen = plen;
    c.offset = off;
    c.delta = dt;
    if (op == OP_WRITE) written_map[s][p] = 1'b1;
    if (op != OP_UNUSED) active_cmds++;
    cmds_queued++;
    cmd_queue.push_back(c);
  endtask

  // Fill every entry the new length will reach, then set the style up.
  task automatic queue_style_setup(input logic [STYLE_W-1:0] s, input logic [PLEN_W-1:0] plen,
                                   input logic [OFFSET_W-1:0] off);
    int used;
    used = (plen > NDEPTH) ? NDEPTH : plen;
    for (int p = 0; p < used; p++) begin
      if (!written_map[s][p]) begin
        queue_op(OP_WRITE, s, POS_W'(p), LEVEL_W'($urandom), PLEN_W'($urandom),
                 OFFSET_W'($urandom), DELTA_W'($urandom));
      end
    end
    queue_op(OP_SETUP, s, POS_W'($urandom), LEVEL_W'($urandom), plen, off,
             DELTA_W'($urandom));
  endtask

  // Input driver: offers queued commands with random gaps between them.
  int in_gap = 0;
  bit in_burst = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else if (in_valid && !in_taken) begin
      // Hold the transaction until the block takes it.
    end else if (in_gap != 0) begin
      in_valid <= 1'b0;
      in_gap <= in_gap - 1;
    end else if (cmd_queue.size() != 0) begin
      drv_cmd <= cmd_queue.pop_front();
      in_valid <= 1'b1;
      in_gap <= idle_draw(in_burst);
      if ($urandom_range(0, 24) == 0) in_burst <= !in_burst;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Input side: predict the results of every accepted command.
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        cmds_taken++;
        update_styles(drv_cmd);
      end
    end
  end

  // Receiver: stalls each result a random number of cycles once it shows, and
  // holds off for a long stretch once so that the input backs up.
  int out_wait = 0;
  int hold_left = 0;
  bit out_burst = 1'b0;

  always @(negedge clk) begin : pace_results
    int w;
    if (rst) begin
      out_ready <= 1'b0;
      out_wait <= 0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (out_taken && results_taken == HOLD_AFTER) begin
      out_ready <= 1'b0;
      hold_left <= LONG_HOLD;
    end else if (out_taken) begin
      w = idle_draw(out_burst);
      if ($urandom_range(0, 24) == 0) out_burst <= !out_burst;
      out_ready <= (w == 0);
      out_wait <= w;
    end else if (out_valid && out_wait != 0) begin
      out_ready <= (out_wait == 1);
      out_wait <= out_wait - 1;
    end else begin
      out_ready <= (out_wait == 0);
    end
  end

  // Output side: compare each result with the oldest prediction.
  always @(posedge clk) begin : check_scales
    scale_rec_t want;
    if (rst) begin
      out_taken <= 1'b0;
    end else begin
      out_taken <= out_valid && out_ready;
      if (out_valid && out_ready) begin
        results_taken <= results_taken + 1;
        if (expected_scales.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, style_index %0d scale %0d last %0b",
                   $time, res_style, res_scale, res_last);
        end else begin
          want = expected_scales.pop_front();
          if (res_style !== want.style_index) begin
            errors++;
            $display("%0t: style_index expected %0d, got %0d",
                     $time, want.style_index, res_style);
          end
          if (res_scale !== want.scale) begin
            errors++;
            $display("%0t: scale of style %0d expected %0d, got %0d",
                     $time, want.style_index, want.scale, res_scale);
          end
          if (res_last !== want.last) begin
            errors++;
            $display("%0t: last of style %0d expected %0b, got %0b",
                     $time, want.style_index, want.last, res_last);
          end
        end
      end
    end
  end

  // Stimulus: a directed phase at the reset frame rate, then random phases, each
  // under its own frame rate written while the block is idle.
  initial begin : run_phases
    logic [RATE_W-1:0]   phase_rate [1:4];
    logic [PLEN_W-1:0]   plen;
    logic [STYLE_W-1:0]  s;
    logic [OFFSET_W-1:0] off;
    logic [DELTA_W-1:0]  dt;
    int start_count;
    int pick;

    phase_rate[1] = 8'd255;
    phase_rate[2] = 8'd1;
    phase_rate[3] = 8'd0;
    phase_rate[4] = RATE_W'($urandom_range(2, 254));

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    for (int p = 0; p <= 4; p++) begin
      if (p == 0) begin
        // All lengths are zero after reset.
        queue_op(OP_TICK, 6'($urandom), 6'($urandom), 5'($urandom), 7'($urandom),
                 16'($urandom), 16'd0);
        // Lowest level, highest level and a level that clamps.
        queue_op(OP_WRITE, 6'd0, 6'd0, 5'd0, 7'($urandom), 16'($urandom), 16'($urandom));
        queue_op(OP_WRITE, 6'd0, 6'd1, 5'd25, 7'($urandom), 16'($urandom), 16'($urandom));
        queue_op(OP_WRITE, 6'd0, 6'd2, 5'd31, 7'($urandom), 16'($urandom), 16'($urandom));
        queue_style_setup(6'd0, 7'd3, 16'd0);
        // Length one on the last style, started long ago.
        queue_op(OP_WRITE, 6'd63, 6'd0, 5'd12, 7'($urandom), 16'($urandom), 16'($urandom));
        queue_style_setup(6'd63, 7'd1, 16'h8000);
        // A start far in the future keeps the first entry.
        queue_op(OP_WRITE, 6'd5, 6'd0, 5'd7, 7'($urandom), 16'($urandom), 16'($urandom));
        queue_op(OP_WRITE, 6'd5, 6'd1, 5'd3, 7'($urandom), 16'($urandom), 16'($urandom));
        queue_style_setup(6'd5, 7'd2, 16'h7FFF);
        queue_op(OP_WRITE, 6'd1, 6'd63, 5'd1, 7'($urandom), 16'($urandom), 16'($urandom));
        queue_style_setup(6'd7, 7'd0, 16'd100);
        queue_op(OP_UNUSED, 6'($urandom), 6'($urandom), 5'($urandom), 7'($urandom),
                 16'($urandom), 16'($urandom));
        queue_op(OP_TICK, 6'($urandom), 6'($urandom), 5'($urandom), 7'($urandom),
                 16'($urandom), 16'd1000);
        queue_op(OP_TICK, 6'($urandom), 6'($urandom), 5'($urandom), 7'($urandom),
                 16'($urandom), 16'hFFFF);
        queue_op(OP_TICK, 6'($urandom), 6'($urandom), 5'($urandom), 7'($urandom),
                 16'($urandom), 16'd0);
        queue_style_setup(6'd0, 7'd2, -16'sd5000);
        queue_op(OP_TICK, 6'($urandom), 6'($urandom), 5'($urandom), 7'($urandom),
                 16'($urandom), 16'd777);
      end else begin
        // Program the frame rate through the configuration port.
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {REG_FRAME_RATE, 2'b00};
        pwdata = APB_DATA_W'(phase_rate[p]);
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        rate_cfg = phase_rate[p];
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;

        start_count = active_cmds;
        // One style runs the full pattern depth with a length that saturates.
        if (p == 1) queue_style_setup(6'd61, 7'($urandom_range(65, 127)), 16'($urandom));
        while (active_cmds - start_count < PHASE_CMDS) begin
          pick = $urandom_range(0, 19);
          if (pick < 9) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) plen = 7'($urandom_range(0, 6));
            else if (pick < 18) plen = 7'($urandom_range(7, 20));
            else if (pick < 19) plen = 7'($urandom_range(21, 64));
            else plen = 7'($urandom_range(65, 127));
            // Long patterns stay on two styles so that filling them stays rare.
            s = (plen > 20) ? 6'($urandom_range(60, 61)) : 6'($urandom);
            off = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                               : 16'($urandom_range(0, 8000) - 4000);
            queue_style_setup(s, plen, off);
          end else if (pick < 15) begin
            dt = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
            queue_op(OP_TICK, 6'($urandom), 6'($urandom), 5'($urandom), 7'($urandom),
                     16'($urandom), dt);
          end else if (pick < 17) begin
            queue_op(OP_WRITE, 6'($urandom), 6'($urandom), 5'($urandom), 7'($urandom),
                     16'($urandom), 16'($urandom));
          end else if (pick < 18) begin
            queue_op(OP_UNUSED, 6'($urandom), 6'($urandom), 5'($urandom), 7'($urandom),
                     16'($urandom), 16'($urandom));
          end else begin
            queue_style_setup(6'($urandom), 7'($urandom_range(0, 2)), 16'($urandom));
          end
        end
        queue_op(OP_TICK, 6'($urandom), 6'($urandom), 5'($urandom), 7'($urandom),
                 16'($urandom), 16'($urandom_range(0, 2000)));
      end

      // Let the phase drain before the next register write.
      while (cmds_taken != cmds_queued || expected_scales.size() != 0) @(negedge clk);
      repeat (24) @(negedge clk);
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_scales.size() != 0)
      $display("%0t: %0d predicted results never arrived", $time, expected_scales.size());
    if (errors == 0 && expected_scales.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(30_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/lps_pkg.sv
hw/rtl/light_pattern_sequencer_unit.sv
tb/light_pattern_sequencer_unit_tb.sv
